// ----- sv/sbot_pkg.sv -----
`timescale 1ns / 1ps
package sbot_pkg;

  // Default coordinate width
  localparam int unsigned CoordBitsDef = 16;

  // Configuration register index width and codes
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SLOPE_LEFT_X  = 3'd0,
    CFG_SLOPE_LEFT_Y  = 3'd1,
    CFG_SLOPE_RIGHT_X = 3'd2,
    CFG_SLOPE_RIGHT_Y = 3'd3,
    CFG_BASE_Y        = 3'd4
  } cfg_idx_e;

endpackage

// ----- sv/slope_box_overlap_test_unit.sv -----
`timescale 1ns / 1ps
// Channel   | Dir | Fields (lowest bit first)
// ----------+-----+-------------------------------------------------------------
// s_axis    | in  | tdata: box_left, box_right, box_top, box_bottom
// m_axis    | out | tdata: x_hit, y_hit, surface_valid, surface_y,
//           |     |        most_right_x, most_left_x, config_error
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One item per cycle while the output is not stalled; COORD_BITS + 3 register
// stages (decode, multiply, one quotient bit per divider stage, result register).
// The two restoring dividers, one bit a stage, set the pipeline depth.
// Reset clears valid bits and loads the reset values of the configuration registers.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module slope_box_overlap_test_unit #(
  parameter int unsigned COORD_BITS = sbot_pkg::CoordBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [sbot_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [COORD_BITS-1:0]                 cfg_data_i,
  // Input item: box_left, box_right, box_top, box_bottom
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // Result: x_hit, y_hit, surface_valid, surface_y, most_right_x,
  //         most_left_x, config_error
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((3*COORD_BITS+4+7)/8)*8-1:0]   m_axis_tdata
);
  import sbot_pkg::*;

  localparam int unsigned W       = COORD_BITS;
  localparam int unsigned OutBits = ((3*COORD_BITS+4+7)/8)*8;

  typedef struct packed {
    logic                err;
    logic                ox;
    logic                oy_flat;
    logic                dflat;
    logic                dneg;
    logic                h_interp;
    logic signed [W-1:0] h_corner;
    logic                mr_interp;
    logic                mr_lx;
    logic                ml_interp;
    logic                ml_rx;
    logic signed [W-1:0] top;
    logic signed [W-1:0] bottom;
  } meta_t;

  typedef struct packed {
    meta_t          meta;
    logic [W-1:0]   da;
    logic [W-1:0]   db;
    logic [W-1:0]   rem_a;
    logic [W-1:0]   lq_a;
    logic [W-1:0]   rem_b;
    logic [W-1:0]   lq_b;
  } div_t;

  // Configuration registers
  logic signed [W-1:0] lx_q, ly_q, rx_q, ry_q, by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0;
      ly_q <= '0;
      rx_q <= W'(1);
      ry_q <= '0;
      by_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLOPE_LEFT_X:  lx_q <= cfg_data_i;
        CFG_SLOPE_LEFT_Y:  ly_q <= cfg_data_i;
        CFG_SLOPE_RIGHT_X: rx_q <= cfg_data_i;
        CFG_SLOPE_RIGHT_Y: ry_q <= cfg_data_i;
        CFG_BASE_Y:        by_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic advance;
  logic s_fire;
  logic out_v_q;

  assign advance       = !out_v_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign s_fire        = s_axis_tvalid && advance;

  // Stage 1: decode box against slope
  logic signed [W-1:0] left, right, top, bottom;
  logic signed [W:0]   dxw, dyw, xoff, toff;
  logic                dpos, dneg, in_l, in_r;
  meta_t               meta1_d;
  logic [W-1:0]        b1_d, t1_d, magdy1_d;

  assign left   = s_axis_tdata[0 +: W];
  assign right  = s_axis_tdata[W +: W];
  assign top    = s_axis_tdata[2*W +: W];
  assign bottom = s_axis_tdata[3*W +: W];

  always_comb begin
    dxw  = {rx_q[W-1], rx_q} - {lx_q[W-1], lx_q};
    dyw  = {ry_q[W-1], ry_q} - {ly_q[W-1], ly_q};
    dpos = !dyw[W] && (dyw != '0);
    dneg = dyw[W];
    in_l = (left >= lx_q) && (left <= rx_q);
    in_r = (right >= lx_q) && (right <= rx_q);
    magdy1_d = dneg ? W'(-dyw) : dyw[W-1:0];
    xoff = dpos ? ({left[W-1], left} - {lx_q[W-1], lx_q})
                : ({right[W-1], right} - {lx_q[W-1], lx_q});
    toff = dpos ? ({bottom[W-1], bottom} - {ly_q[W-1], ly_q})
                : ({bottom[W-1], bottom} - {ry_q[W-1], ry_q});
    b1_d = xoff[W-1:0];
    t1_d = toff[W-1:0];

    meta1_d           = '0;
    meta1_d.err       = !(lx_q < rx_q);
    meta1_d.dflat     = !dpos && !dneg;
    meta1_d.dneg      = dneg;
    meta1_d.top       = top;
    meta1_d.bottom    = bottom;
    meta1_d.oy_flat   = (bottom >= ly_q) && (top <= by_q);
    meta1_d.h_corner  = ly_q;
    if (dpos) begin
      if (in_l) begin
        meta1_d.ox       = 1'b1;
        meta1_d.h_interp = 1'b1;
      end else if ((left <= lx_q) && (right >= lx_q)) begin
        meta1_d.ox = 1'b1;
      end
    end else if (dneg) begin
      meta1_d.h_corner = ry_q;
      if (in_r) begin
        meta1_d.ox       = 1'b1;
        meta1_d.h_interp = 1'b1;
      end else if ((left <= rx_q) && (right >= rx_q)) begin
        meta1_d.ox = 1'b1;
      end
    end else begin
      meta1_d.ox = (right >= lx_q) && (left <= rx_q);
    end
    // Rightmost x at the bottom
    if (dpos) begin
      if (bottom <= ly_q) meta1_d.mr_lx = 1'b1;
      else if (bottom < ry_q) meta1_d.mr_interp = 1'b1;
    end
    // Leftmost x at the bottom
    if (dneg) begin
      if (bottom <= ry_q) meta1_d.ml_rx = 1'b1;
      else if (bottom < ly_q) meta1_d.ml_interp = 1'b1;
    end
  end

  logic         v1_q;
  meta_t        meta1_q;
  logic [W-1:0] b1_q, t1_q, magdy1_q, dx1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (advance) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      meta1_q  <= meta1_d;
      b1_q     <= b1_d;
      t1_q     <= t1_d;
      magdy1_q <= magdy1_d;
      dx1_q    <= dxw[W-1:0];
    end
  end

  // Stage 2: products feeding the dividers
  logic [2*W-1:0] pa, pb;

  assign pa = (2*W)'(magdy1_q) * (2*W)'(b1_q);
  assign pb = (2*W)'(dx1_q) * (2*W)'(t1_q);

  // Divider stages: element 0 is loaded from the products
  logic [W:0] dv_q;
  div_t       dv_s_q [W+1];
  div_t       dv_s_d [W+1];

  always_comb begin
    dv_s_d[0].meta  = meta1_q;
    dv_s_d[0].da    = dx1_q;
    dv_s_d[0].db    = magdy1_q;
    dv_s_d[0].rem_a = pa[2*W-1:W];
    dv_s_d[0].lq_a  = pa[W-1:0];
    dv_s_d[0].rem_b = pb[2*W-1:W];
    dv_s_d[0].lq_b  = pb[W-1:0];
  end

  // One quotient bit per stage for both dividers
  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [W:0] trial_a, trial_b;
    always_comb begin
      trial_a = {dv_s_q[k-1].rem_a, dv_s_q[k-1].lq_a[W-1]};
      trial_b = {dv_s_q[k-1].rem_b, dv_s_q[k-1].lq_b[W-1]};
      dv_s_d[k] = dv_s_q[k-1];
      if (trial_a >= {1'b0, dv_s_q[k-1].da}) begin
        dv_s_d[k].rem_a = W'(trial_a - {1'b0, dv_s_q[k-1].da});
        dv_s_d[k].lq_a  = {dv_s_q[k-1].lq_a[W-2:0], 1'b1};
      end else begin
        dv_s_d[k].rem_a = trial_a[W-1:0];
        dv_s_d[k].lq_a  = {dv_s_q[k-1].lq_a[W-2:0], 1'b0};
      end
      if (trial_b >= {1'b0, dv_s_q[k-1].db}) begin
        dv_s_d[k].rem_b = W'(trial_b - {1'b0, dv_s_q[k-1].db});
        dv_s_d[k].lq_b  = {dv_s_q[k-1].lq_b[W-2:0], 1'b1};
      end else begin
        dv_s_d[k].rem_b = trial_b[W-1:0];
        dv_s_d[k].lq_b  = {dv_s_q[k-1].lq_b[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (advance) begin
      dv_q <= {dv_q[W-1:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int unsigned i = 0; i <= W; i++) begin
        dv_s_q[i] <= dv_s_d[i];
      end
    end
  end

  // Final stage: assemble the result
  div_t                fin;
  logic signed [W+1:0] hs, h;
  logic                oy;
  logic [W-1:0]        surf, mr, ml;
  logic [OutBits-1:0]  out_d;

  assign fin = dv_s_q[W];

  always_comb begin
    hs = fin.meta.dneg ? -(W+2)'(fin.lq_a) : (W+2)'(fin.lq_a);
    h  = fin.meta.h_interp ? ((W+2)'(ly_q) + hs) : (W+2)'(fin.meta.h_corner);
    if (fin.meta.dflat) begin
      oy = fin.meta.oy_flat;
    end else begin
      oy = fin.meta.ox && !(((W+2)'(fin.meta.bottom) < h) || (fin.meta.top > by_q));
    end
    surf = fin.meta.ox ? h[W-1:0] : '0;
    if (fin.meta.mr_interp) mr = W'(lx_q + fin.lq_b);
    else if (fin.meta.mr_lx) mr = lx_q;
    else                     mr = rx_q;
    if (fin.meta.ml_interp) ml = W'(rx_q - fin.lq_b);
    else if (fin.meta.ml_rx) ml = rx_q;
    else                     ml = lx_q;

    out_d = '0;
    if (fin.meta.err) begin
      out_d[3*W+3] = 1'b1;
    end else begin
      out_d[0]          = fin.meta.ox;
      out_d[1]          = oy;
      out_d[2]          = fin.meta.ox;
      out_d[3 +: W]     = surf;
      out_d[3+W +: W]   = mr;
      out_d[3+2*W +: W] = ml;
    end
  end

  // Output register
  logic [OutBits-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= dv_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  // An accepted item enters stage one
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> v1_q) else $error("accepted item lost at stage one");

  // A stall holds stage one
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !advance) |=> v1_q) else $error("stage one dropped on stall");

  // A bad configuration clears every other field
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3*W+3]) |-> (m_axis_tdata[3*W+2:0] == '0))
    else $error("fields set with config error");

  // No surface height without horizontal overlap
  a_surf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[3 +: W] == '0))
    else $error("surface without overlap");
`endif

endmodule
